// ===== sv/lgge_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and codes of the life grid generation engine
package lgge_pkg;

    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 64;
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int CNT_W    = $clog2(MAX_ROWS + 2);
    localparam int CFG_W    = 7;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    // opcodes
    localparam logic [1:0] OP_ADVANCE = 2'd0;
    localparam logic [1:0] OP_TOGGLE  = 2'd1;
    localparam logic [1:0] OP_READ    = 2'd2;
    localparam logic [1:0] OP_CLEAR   = 2'd3;

    // register indexes
    localparam logic [PADDR_W-3:0] REG_ROWS = 1'b0;
    localparam logic [PADDR_W-3:0] REG_COLS = 1'b1;

    typedef struct packed {
        logic [1:0]       opcode;
        logic [ROW_W-1:0] row_index;
        logic [COL_W-1:0] col_index;
    } t_in_item;

    typedef struct packed {
        logic       cell_alive;
        logic [3:0] neighbour_count;
        logic       grid_empty;
    } t_out_item;

    typedef struct packed {
        logic [CNT_W-1:0]    rows_eff;
        logic [COL_W:0]      cols_eff;
        logic [MAX_COLS-1:0] col_mask;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic sweep;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic sweep_done;
    } t_dp_sts;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_REPORT
    } t_state;

endpackage

// ===== sv/lgge_cfg.sv =====
`timescale 1ns / 1ps
// apb register file holding the active grid size
module lgge_cfg import lgge_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    logic [CFG_W-1:0] r_rows;
    logic [CFG_W-1:0] r_cols;
    logic             w_wr;
    logic [CFG_W-1:0] w_rows_max;
    logic [CFG_W-1:0] w_cols_max;

    assign pready     = 1'b1;
    assign w_wr       = psel && penable && pwrite;
    assign w_rows_max = CFG_W'(MAX_ROWS);
    assign w_cols_max = CFG_W'(MAX_COLS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= CFG_W'(64);
            r_cols <= CFG_W'(64);
        end else if (w_wr) begin
            case (paddr[PADDR_W-1:2])
                REG_ROWS: r_rows <= pwdata[CFG_W-1:0];
                REG_COLS: r_cols <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[PADDR_W-1:2])
            REG_ROWS: prdata = PDATA_W'(r_rows);
            REG_COLS: prdata = PDATA_W'(r_cols);
            default:  prdata = '0;
        endcase
    end

    // zero acts as one, anything above the built size acts as the built size
    always_comb begin
        if (r_rows == '0)
            o_cfg.rows_eff = CNT_W'(1);
        else if (r_rows > w_rows_max)
            o_cfg.rows_eff = CNT_W'(MAX_ROWS);
        else
            o_cfg.rows_eff = CNT_W'(r_rows);

        if (r_cols == '0)
            o_cfg.cols_eff = (COL_W + 1)'(1);
        else if (r_cols > w_cols_max)
            o_cfg.cols_eff = (COL_W + 1)'(MAX_COLS);
        else
            o_cfg.cols_eff = (COL_W + 1)'(r_cols);

        for (int i = 0; i < MAX_COLS; i++) begin
            o_cfg.col_mask[i] = ((COL_W + 1)'(i) < o_cfg.cols_eff);
        end
    end

endmodule

// ===== sv/lgge_ctrl.sv =====
`timescale 1ns / 1ps
// controller: sequences the row sweep and the result strobe
module lgge_ctrl import lgge_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [1:0] i_opcode,
    input  t_dp_sts    i_sts,
    output t_dp_cmd    o_cmd,
    output logic       o_busy,
    output logic       o_done
);

    t_state r_state;
    t_state n_state;
    logic   r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_REPORT);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    // clear needs no sweep
                    n_state = (i_opcode == OP_CLEAR) ? S_REPORT : S_SWEEP;
                end
            end
            S_SWEEP: begin
                if (i_sts.sweep_done) n_state = S_REPORT;
            end
            S_REPORT: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.load  = 1'b0;
        o_cmd.sweep = 1'b0;
        o_cmd.emit  = 1'b0;
        o_busy      = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_cmd.load = i_start;
                o_busy     = 1'b0;
            end
            S_SWEEP:  o_cmd.sweep = 1'b1;
            S_REPORT: o_cmd.emit  = 1'b1;
            default:  o_busy      = 1'b1;
        endcase
    end

    assign o_done = r_done;

endmodule

// ===== sv/lgge_dp.sv =====
`timescale 1ns / 1ps
// datapath: grid memory, row pipeline, life rule and result assembly
module lgge_dp import lgge_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  t_dp_cmd   i_cmd,
    input  t_in_item  i_item,
    output t_dp_sts   o_sts,
    output t_out_item o_result
);

    logic [MAX_COLS-1:0] mem [MAX_ROWS];
    logic [MAX_ROWS-1:0] r_row_valid;

    logic [1:0]          r_op;
    logic [ROW_W-1:0]    r_row;
    logic [COL_W-1:0]    r_col;
    logic                r_inside;
    logic [CNT_W-1:0]    r_cnt;
    logic [MAX_COLS-1:0] r_rd_data;
    logic                r_rd_live;
    logic [MAX_COLS-1:0] r_prev;
    logic [MAX_COLS-1:0] r_cur;
    logic [MAX_COLS-1:0] r_cur_raw;
    logic [MAX_COLS-1:0] r_above;
    logic [MAX_COLS-1:0] r_mid;
    logic [MAX_COLS-1:0] r_below;
    logic                r_any_live;
    t_out_item           r_result;

    logic                w_inside;
    logic                w_issue;
    logic                w_row_act;
    logic                w_hit;
    logic                w_wr;
    logic [CNT_W-1:0]    w_j;
    logic [CNT_W-1:0]    w_row_ext;
    logic [MAX_COLS-1:0] w_next_raw;
    logic [MAX_COLS-1:0] w_next;
    logic [MAX_COLS+1:0] w_pa;
    logic [MAX_COLS+1:0] w_pc;
    logic [MAX_COLS+1:0] w_pb;
    logic [3:0]          w_n;
    logic [MAX_COLS-1:0] w_fresh;
    logic [MAX_COLS-1:0] w_toggle_bit;
    logic [MAX_COLS-1:0] w_new_raw;
    logic [MAX_COLS-1:0] w_new;
    logic [MAX_COLS+1:0] w_qa;
    logic [MAX_COLS+1:0] w_qc;
    logic [MAX_COLS+1:0] w_qb;
    logic [2:0]          w_ta;
    logic [2:0]          w_tc;
    logic [2:0]          w_tb;
    logic [3:0]          w_count;

    assign w_inside = (CNT_W'(i_item.row_index) < i_cfg.rows_eff)
                   && ((COL_W + 1)'(i_item.col_index) < i_cfg.cols_eff);

    // read row r_cnt now, its data lands in the next cycle; row r_cnt-2 is rebuilt
    assign w_issue    = i_cmd.sweep && (r_cnt < i_cfg.rows_eff);
    assign w_row_act  = i_cmd.sweep && (r_cnt >= CNT_W'(2));
    assign w_j        = r_cnt - CNT_W'(2);
    assign w_row_ext  = CNT_W'(r_row);
    assign w_next_raw = r_rd_live ? r_rd_data : '0;
    assign w_next     = w_next_raw & i_cfg.col_mask;
    assign w_hit      = r_inside && (w_j == w_row_ext);

    assign o_sts.sweep_done = i_cmd.sweep && (r_cnt == i_cfg.rows_eff + CNT_W'(1));

    // b3/s23 across the whole row at once
    always_comb begin
        w_pa = {1'b0, r_prev, 1'b0};
        w_pc = {1'b0, r_cur, 1'b0};
        w_pb = {1'b0, w_next, 1'b0};
        w_n  = '0;
        for (int i = 0; i < MAX_COLS; i++) begin
            w_n = 4'(w_pa[i]) + 4'(w_pa[i+1]) + 4'(w_pa[i+2])
                + 4'(w_pc[i]) + 4'(w_pc[i+2])
                + 4'(w_pb[i]) + 4'(w_pb[i+1]) + 4'(w_pb[i+2]);
            w_fresh[i] = (w_n == 4'd3) || ((w_n == 4'd2) && r_cur[i]);
        end
    end

    always_comb begin
        w_toggle_bit = '0;
        w_toggle_bit[r_col] = w_hit;
        case (r_op)
            OP_ADVANCE: w_new_raw = (w_fresh & i_cfg.col_mask)
                                  | (r_cur_raw & ~i_cfg.col_mask);
            OP_TOGGLE:  w_new_raw = r_cur_raw ^ w_toggle_bit;
            default:    w_new_raw = r_cur_raw;
        endcase
        w_new = w_new_raw & i_cfg.col_mask;
        w_wr  = w_row_act && ((r_op == OP_ADVANCE) || ((r_op == OP_TOGGLE) && w_hit));
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) mem[w_j[ROW_W-1:0]] <= w_new_raw;
        r_rd_data <= mem[r_cnt[ROW_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
            r_cnt       <= '0;
            r_rd_live   <= 1'b0;
            r_any_live  <= 1'b0;
        end else if (i_cmd.load) begin
            r_cnt      <= '0;
            r_rd_live  <= 1'b0;
            r_any_live <= 1'b0;
            if (i_item.opcode == OP_CLEAR) r_row_valid <= '0;
        end else if (i_cmd.sweep) begin
            r_cnt     <= r_cnt + CNT_W'(1);
            r_rd_live <= w_issue && r_row_valid[r_cnt[ROW_W-1:0]];
            if (w_wr) r_row_valid[w_j[ROW_W-1:0]] <= 1'b1;
            if (w_row_act && (w_new != '0)) r_any_live <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op      <= i_item.opcode;
            r_row     <= i_item.row_index;
            r_col     <= i_item.col_index;
            r_inside  <= w_inside;
            r_prev    <= '0;
            r_cur     <= '0;
            r_cur_raw <= '0;
            r_above   <= '0;
            r_mid     <= '0;
            r_below   <= '0;
        end else if (i_cmd.sweep) begin
            r_prev    <= r_cur;
            r_cur     <= w_next;
            r_cur_raw <= w_next_raw;
            // keep the rebuilt rows around the addressed cell
            if (w_row_act) begin
                if (w_j + CNT_W'(1) == w_row_ext) r_above <= w_new;
                if (w_j == w_row_ext)             r_mid   <= w_new;
                if (w_j == w_row_ext + CNT_W'(1)) r_below <= w_new;
            end
        end
    end

    always_comb begin
        w_qa    = {1'b0, r_above, 1'b0};
        w_qc    = {1'b0, r_mid, 1'b0};
        w_qb    = {1'b0, r_below, 1'b0};
        w_ta    = w_qa[r_col +: 3];
        w_tc    = w_qc[r_col +: 3];
        w_tb    = w_qb[r_col +: 3];
        w_count = 4'(w_ta[0]) + 4'(w_ta[1]) + 4'(w_ta[2])
                + 4'(w_tc[0]) + 4'(w_tc[2])
                + 4'(w_tb[0]) + 4'(w_tb[1]) + 4'(w_tb[2]);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_result.cell_alive      <= r_inside && w_tc[1];
            r_result.neighbour_count <= r_inside ? w_count : 4'd0;
            r_result.grid_empty      <= !r_any_live;
        end
    end

    assign o_result = r_result;

endmodule

// ===== sv/life_grid_generation_engine_top.sv =====
`timescale 1ns / 1ps
// top level: apb registers, controller and datapath of the life grid engine
// advance, toggle and read: start leads to the row sweep, then to the report state that registers the strobe
// clear: start goes straight to the report state that registers the strobe, with no sweep
// the sweep reads one grid row per cycle through a single memory read port
// next start is taken in the strobe cycle, so the engine works on one item at a time
// synchronous active-low reset clears the grid and sets 64 x 64; results cannot stall
module life_grid_generation_engine_top import lgge_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  t_in_item           i_item,
    output logic               o_done,
    output t_out_item          o_result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    t_cfg    w_cfg;
    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    lgge_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    lgge_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_opcode (i_item.opcode),
        .i_sts    (w_sts),
        .o_cmd    (w_cmd),
        .o_busy   (busy),
        .o_done   (o_done)
    );

    lgge_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_cmd    (w_cmd),
        .i_item   (i_item),
        .o_sts    (w_sts),
        .o_result (o_result)
    );

    // a taken transaction keeps the engine busy next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("engine not busy after taking a transaction");

    // the strobe only shows once the controller is back in idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    // one strobe per transaction
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for two cycles");

    // an empty grid cannot report a live cell
    a_empty_dead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.grid_empty) |-> !o_result.cell_alive)
        else $error("live cell reported on an empty grid");

endmodule
